// File: hdl/frequency_table_statistics_unit_macros.svh
// Assertion helpers shared by the statistics unit.
`ifndef FREQUENCY_TABLE_STATISTICS_UNIT_MACROS_SVH
`define FREQUENCY_TABLE_STATISTICS_UNIT_MACROS_SVH

// Same-cycle implication, checked on clk_i outside of reset.
`define FTSU_ASSERT_NOW(lbl, ant, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ant) |-> (cons)) else $error(msg);

// Next-cycle implication, checked on clk_i outside of reset.
`define FTSU_ASSERT_NEXT(lbl, ant, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ant) |=> (cons)) else $error(msg);

`endif

// File: hdl/ftsu_pkg.sv
package ftsu_pkg;

  localparam int MaxEntries = 64;
  localparam int IdxW       = $clog2(MaxEntries);
  localparam int EntW       = IdxW + 1;
  localparam int ValW       = 8;
  localparam int FrqW       = 16;
  localparam int TotW       = 22;
  localparam int WsW        = 30;
  localparam int SqW        = 38;
  localparam int HalfSqW    = SqW / 2;
  localparam int DiffW      = 60;
  localparam int DivNW      = 76;
  localparam int DivDW      = TotW;
  localparam int DivCntW    = $clog2(DivNW);
  localparam int RootW      = 32;
  localparam int CvScale    = 100 * 256;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_ZERO_FREQ = 2'd1,
    ST_OVERFLOW  = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_MUL_LO,
    OP_MUL_HI,
    OP_MUL_SQ,
    OP_SUM,
    OP_DIFF,
    OP_CV_MUL
  } op_e;

  typedef enum logic [1:0] {
    DIV_VAR1,
    DIV_VAR2,
    DIV_MEAN,
    DIV_CV
  } div_sel_e;

  typedef enum logic [4:0] {
    S_IDLE, S_DRAIN1, S_DRAIN2,
    S_MUL_LO, S_MUL_HI, S_MUL_SQ, S_SUM, S_DIFF,
    S_DIV_VAR1, S_WAIT_VAR1, S_DIV_VAR2, S_WAIT_VAR2,
    S_SQRT, S_WAIT_SQRT,
    S_DIV_MEAN, S_WAIT_MEAN, S_CV_MUL, S_DIV_CV, S_WAIT_CV,
    S_MED_INIT, S_MED_READ, S_MED_CHK, S_DONE
  } state_e;

  typedef struct packed {
    logic     accept;
    logic     clear;
    logic     res_clear;
    op_e      op;
    logic     div_start;
    div_sel_e div_sel;
    logic     sqrt_start;
    logic     med_init;
    logic     med_step;
  } cmd_t;

  typedef struct packed {
    logic t_zero;
    logic mean_zero;
    logic med_hit;
    logic div_done;
    logic sqrt_done;
  } stat_t;

endpackage

// File: hdl/ftsu_div.sv
module ftsu_div (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [ftsu_pkg::DivNW-1:0] num_i,
  input  logic [ftsu_pkg::DivDW-1:0] den_i,
  output logic                      done_o,
  output logic [ftsu_pkg::DivNW-1:0] quo_o
);
  import ftsu_pkg::*;

  logic               active_q, done_q;
  logic [DivCntW-1:0] cnt_q;
  logic [DivDW-1:0]   den_q, rem_q;
  logic [DivNW-1:0]   quo_q;
  logic [DivDW:0]     trial;
  logic               ge;

  // Restoring division, one quotient bit a cycle.
  assign trial = {rem_q, quo_q[DivNW-1]};
  assign ge    = trial >= {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      done_q   <= 1'b0;
      cnt_q    <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        active_q <= 1'b1;
        cnt_q    <= '0;
      end else if (active_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == DivCntW'(DivNW - 1)) begin
          active_q <= 1'b0;
          done_q   <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      den_q <= den_i;
      rem_q <= '0;
      quo_q <= num_i;
    end else if (active_q) begin
      rem_q <= ge ? DivDW'(trial - {1'b0, den_q}) : trial[DivDW-1:0];
      quo_q <= {quo_q[DivNW-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;
endmodule

// File: hdl/ftsu_sqrt.sv
module ftsu_sqrt (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [ftsu_pkg::RootW-1:0] x_i,
  output logic                      done_o,
  output logic [ftsu_pkg::RootW-1:0] root_o
);
  import ftsu_pkg::*;

  logic             active_q, done_q;
  logic [RootW-1:0] x_q, root_q, bit_q;
  logic [RootW:0]   sum;
  logic             ge;

  // Two radicand bits a cycle.
  assign sum = {1'b0, root_q} + {1'b0, bit_q};
  assign ge  = {1'b0, x_q} >= sum;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      done_q   <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        active_q <= 1'b1;
      end else if (active_q && bit_q[0]) begin
        active_q <= 1'b0;
        done_q   <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      x_q    <= x_i;
      root_q <= '0;
      bit_q  <= RootW'(1) << (RootW - 2);
    end else if (active_q) begin
      if (ge) begin
        x_q    <= x_q - sum[RootW-1:0];
        root_q <= (root_q >> 1) + bit_q;
      end else begin
        root_q <= root_q >> 1;
      end
      bit_q <= bit_q >> 2;
    end
  end

  assign done_o = done_q;
  assign root_o = root_q;
endmodule

// File: hdl/ftsu_dp.sv
module ftsu_dp (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  ftsu_pkg::cmd_t           cmd_i,
  output ftsu_pkg::stat_t          stat_o,
  input  logic [ftsu_pkg::ValW-1:0] sample_value_i,
  input  logic [ftsu_pkg::FrqW-1:0] frequency_i,
  output logic [15:0]              mean_q8_o,
  output logic [ftsu_pkg::ValW-1:0] mode_value_o,
  output logic [ftsu_pkg::ValW-1:0] median_value_o,
  output logic [15:0]              stddev_q8_o,
  output logic [ftsu_pkg::ValW-1:0] value_range_o,
  output logic [23:0]              variation_pct_q8_o,
  output logic [1:0]               status_o
);
  import ftsu_pkg::*;

  logic [ValW+FrqW-1:0] mem_q [MaxEntries];
  logic [ValW+FrqW-1:0] rd_q;

  logic [EntW-1:0] ent_q;
  logic [TotW-1:0] tot_q;
  logic [WsW-1:0]  ws_q;
  logic [SqW-1:0]  ss_q;
  logic [FrqW-1:0] best_cnt_q;
  logic [ValW-1:0] best_val_q, first_q, last_q;
  status_e         err_q;

  logic                 p1_q, p2_q;
  logic [ValW+FrqW-1:0] fv_q;
  logic [ValW-1:0]      v1_q;
  logic [2*ValW+FrqW-1:0] fvv_q;

  logic [TotW+HalfSqW-1:0] pa_q, pb_q;
  logic [DiffW-1:0]        sq_q, tp_q, d_q;
  logic [DivNW-1:0]        q1_q;
  logic [RootW-1:0]        var_q;
  logic [15:0]             mean_q, sd_q;
  logic [23:0]             cv_q;
  logic [31:0]             cvp_q;

  logic [IdxW-1:0] idx_q;
  logic [TotW-1:0] cum_q;
  logic [TotW:0]   cum_next;
  logic [ValW-1:0] med_q;

  logic              div_done, sqrt_done;
  logic [DivNW-1:0]  div_num, quo;
  logic [DivDW-1:0]  div_den;
  logic [RootW-1:0]  root;
  logic              room;

  assign room = ent_q < EntW'(MaxEntries);

  // Entry intake: stores, counts and best entry in the accept cycle.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ent_q      <= '0;
      tot_q      <= '0;
      best_cnt_q <= '0;
      best_val_q <= '0;
      first_q    <= '0;
      last_q     <= '0;
      err_q      <= ST_OK;
      p1_q       <= 1'b0;
      p2_q       <= 1'b0;
      ws_q       <= '0;
      ss_q       <= '0;
    end else begin
      p1_q <= cmd_i.accept && room;
      p2_q <= p1_q;
      if (p1_q) ws_q <= ws_q + WsW'(fv_q);
      if (p2_q) ss_q <= ss_q + SqW'(fvv_q);
      if (cmd_i.clear) begin
        ent_q      <= '0;
        tot_q      <= '0;
        best_cnt_q <= '0;
        best_val_q <= '0;
        first_q    <= '0;
        last_q     <= '0;
        err_q      <= ST_OK;
        ws_q       <= '0;
        ss_q       <= '0;
      end else if (cmd_i.accept) begin
        if (room) begin
          ent_q  <= ent_q + 1'b1;
          tot_q  <= tot_q + TotW'(frequency_i);
          last_q <= sample_value_i;
          if (ent_q == '0) first_q <= sample_value_i;
          if (frequency_i == '0 && err_q == ST_OK) err_q <= ST_ZERO_FREQ;
          if (frequency_i > best_cnt_q) begin
            best_cnt_q <= frequency_i;
            best_val_q <= sample_value_i;
          end
        end else if (err_q == ST_OK) begin
          err_q <= ST_OVERFLOW;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept && room) mem_q[ent_q[IdxW-1:0]] <= {sample_value_i, frequency_i};
    rd_q  <= mem_q[idx_q];
    fv_q  <= frequency_i * sample_value_i;
    v1_q  <= sample_value_i;
    fvv_q <= fv_q * v1_q;
  end

  // Table statistics, one operation a cycle as commanded; also captures divider quotients and steps the median walk.
  always_ff @(posedge clk_i) begin
    unique case (cmd_i.op)
      OP_MUL_LO: pa_q  <= tot_q * ss_q[HalfSqW-1:0];
      OP_MUL_HI: pb_q  <= tot_q * ss_q[SqW-1:HalfSqW];
      OP_MUL_SQ: sq_q  <= ws_q * ws_q;
      OP_SUM:    tp_q  <= DiffW'({pb_q, {HalfSqW{1'b0}}}) + DiffW'(pa_q);
      OP_DIFF:   d_q   <= tp_q - sq_q;
      OP_CV_MUL: cvp_q <= 32'(sd_q * CvScale);
      default: ;
    endcase
    if (div_done && cmd_i.div_sel == DIV_VAR1) q1_q <= quo;
    if (div_done && cmd_i.div_sel == DIV_VAR2) var_q <= quo[RootW-1:0];
    if (cmd_i.med_init) begin
      idx_q <= '0;
      cum_q <= '0;
    end else if (cmd_i.med_step) begin
      idx_q <= idx_q + 1'b1;
      cum_q <= cum_next[TotW-1:0];
    end
    if (cmd_i.med_step && stat_o.med_hit) med_q <= rd_q[ValW+FrqW-1:FrqW];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mean_q <= '0;
      sd_q   <= '0;
      cv_q   <= '0;
    end else if (cmd_i.res_clear) begin
      mean_q <= '0;
      sd_q   <= '0;
      cv_q   <= '0;
    end else begin
      if (div_done && cmd_i.div_sel == DIV_MEAN)
        mean_q <= (|quo[DivNW-1:16]) ? 16'hFFFF : quo[15:0];
      if (div_done && cmd_i.div_sel == DIV_CV)
        cv_q <= (|quo[DivNW-1:24]) ? 24'hFFFFFF : quo[23:0];
      if (sqrt_done)
        sd_q <= (|root[RootW-1:16]) ? 16'hFFFF : root[15:0];
    end
  end

  always_comb begin
    div_num = '0;
    div_den = tot_q;
    unique case (cmd_i.div_sel)
      DIV_VAR1: div_num = {DivNW'(d_q) << 16};
      DIV_VAR2: div_num = q1_q;
      DIV_MEAN: div_num = DivNW'({ws_q, 8'b0});
      DIV_CV: begin
        div_num = DivNW'(cvp_q);
        div_den = DivDW'(mean_q);
      end
      default: ;
    endcase
  end

  ftsu_div u_div (
    .clk_i, .rst_ni,
    .start_i (cmd_i.div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quo_o   (quo)
  );

  ftsu_sqrt u_sqrt (
    .clk_i, .rst_ni,
    .start_i (cmd_i.sqrt_start),
    .x_i     (var_q),
    .done_o  (sqrt_done),
    .root_o  (root)
  );

  assign cum_next = {1'b0, cum_q} + (TotW+1)'(rd_q[FrqW-1:0]);

  assign stat_o.t_zero    = tot_q == '0;
  assign stat_o.mean_zero = mean_q == '0;
  assign stat_o.med_hit   = cum_next >= (TotW+1)'(tot_q >> 1);
  assign stat_o.div_done  = div_done;
  assign stat_o.sqrt_done = sqrt_done;

  assign mean_q8_o          = mean_q;
  assign mode_value_o       = best_val_q;
  assign median_value_o     = med_q;
  assign stddev_q8_o        = sd_q;
  assign value_range_o      = last_q - first_q;
  assign variation_pct_q8_o = cv_q;
  assign status_o           = err_q;
endmodule

// File: hdl/ftsu_ctrl.sv
module ftsu_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic            final_entry_i,
  input  ftsu_pkg::stat_t stat_i,
  output ftsu_pkg::cmd_t  cmd_o,
  output logic            busy_o,
  output logic            done_o
);
  import ftsu_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= S_IDLE;
    else         state_q <= state_d;
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    cmd_o.op = OP_NONE;
    cmd_o.div_sel = DIV_VAR1;
    unique case (state_q)
      S_IDLE: begin
        cmd_o.accept = start_i;
        if (start_i && final_entry_i) state_d = S_DRAIN1;
      end
      S_DRAIN1: begin
        cmd_o.res_clear = 1'b1;
        state_d = S_DRAIN2;
      end
      S_DRAIN2:  state_d = stat_i.t_zero ? S_MED_INIT : S_MUL_LO;
      S_MUL_LO: begin cmd_o.op = OP_MUL_LO; state_d = S_MUL_HI; end
      S_MUL_HI: begin cmd_o.op = OP_MUL_HI; state_d = S_MUL_SQ; end
      S_MUL_SQ: begin cmd_o.op = OP_MUL_SQ; state_d = S_SUM; end
      S_SUM:    begin cmd_o.op = OP_SUM;    state_d = S_DIFF; end
      S_DIFF:   begin cmd_o.op = OP_DIFF;   state_d = S_DIV_VAR1; end
      S_DIV_VAR1: begin
        cmd_o.div_start = 1'b1;
        state_d = S_WAIT_VAR1;
      end
      S_WAIT_VAR1: if (stat_i.div_done) state_d = S_DIV_VAR2;
      S_DIV_VAR2: begin
        cmd_o.div_sel = DIV_VAR2;
        cmd_o.div_start = 1'b1;
        state_d = S_WAIT_VAR2;
      end
      S_WAIT_VAR2: begin
        cmd_o.div_sel = DIV_VAR2;
        if (stat_i.div_done) state_d = S_SQRT;
      end
      S_SQRT: begin
        cmd_o.sqrt_start = 1'b1;
        state_d = S_WAIT_SQRT;
      end
      S_WAIT_SQRT: if (stat_i.sqrt_done) state_d = S_DIV_MEAN;
      S_DIV_MEAN: begin
        cmd_o.div_sel = DIV_MEAN;
        cmd_o.div_start = 1'b1;
        state_d = S_WAIT_MEAN;
      end
      S_WAIT_MEAN: begin
        cmd_o.div_sel = DIV_MEAN;
        if (stat_i.div_done) state_d = S_CV_MUL;
      end
      S_CV_MUL: begin
        cmd_o.op = OP_CV_MUL;
        state_d = stat_i.mean_zero ? S_MED_INIT : S_DIV_CV;
      end
      S_DIV_CV: begin
        cmd_o.div_sel = DIV_CV;
        cmd_o.div_start = 1'b1;
        state_d = S_WAIT_CV;
      end
      S_WAIT_CV: begin
        cmd_o.div_sel = DIV_CV;
        if (stat_i.div_done) state_d = S_MED_INIT;
      end
      S_MED_INIT: begin
        cmd_o.med_init = 1'b1;
        state_d = S_MED_READ;
      end
      S_MED_READ: state_d = S_MED_CHK;
      S_MED_CHK: begin
        cmd_o.med_step = 1'b1;
        state_d = stat_i.med_hit ? S_DONE : S_MED_READ;
      end
      S_DONE: begin
        cmd_o.clear = 1'b1;
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign busy_o = state_q != S_IDLE;
  assign done_o = state_q == S_DONE;
endmodule

// File: hdl/frequency_table_statistics_unit.sv
// From the final entry to done_o the controller drains the product pipeline, forms the
// products, runs four divider passes (76 quotient bits each), a square root and a median
// walk that reads and checks one entry per step until the median entry is found.
// The variation divide is skipped when the mean is zero; all but the walk is skipped on
// a zero total. Throughput: one request per cycle while busy is low; busy holds for
// the whole pass, the receiver cannot stall. Reset clears counters, not the entry memory.
`include "frequency_table_statistics_unit_macros.svh"

module frequency_table_statistics_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [7:0]  sample_value_i,
  input  logic [15:0] frequency_i,
  input  logic        final_entry_i,
  output logic        done_o,
  output logic [15:0] mean_q8_o,
  output logic [7:0]  mode_value_o,
  output logic [7:0]  median_value_o,
  output logic [15:0] stddev_q8_o,
  output logic [7:0]  value_range_o,
  output logic [23:0] variation_pct_q8_o,
  output logic [1:0]  status_o
);
  import ftsu_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  // Sequence the per-table work: drain the product pipeline, then run the
  // variance, root, mean, variation and median steps in turn.
  ftsu_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .start_i       (start),
    .final_entry_i (final_entry_i),
    .stat_i        (stat),
    .cmd_o         (cmd),
    .busy_o        (busy),
    .done_o        (done_o)
  );

  // Hold the table, running sums and the shared divider and root units.
  ftsu_dp u_dp (
    .clk_i, .rst_ni,
    .cmd_i              (cmd),
    .stat_o             (stat),
    .sample_value_i     (sample_value_i),
    .frequency_i        (frequency_i),
    .mean_q8_o          (mean_q8_o),
    .mode_value_o       (mode_value_o),
    .median_value_o     (median_value_o),
    .stddev_q8_o        (stddev_q8_o),
    .value_range_o      (value_range_o),
    .variation_pct_q8_o (variation_pct_q8_o),
    .status_o           (status_o)
  );

  `FTSU_ASSERT_NEXT(a_done_single, done_o, !done_o, "result strobe longer than one cycle")
  `FTSU_ASSERT_NOW(a_done_busy, done_o, busy, "result strobe while idle")
  `FTSU_ASSERT_NEXT(a_final_busy, start && !busy && final_entry_i, busy,
                    "last entry did not start the statistics pass")
endmodule

// File: dv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import ftsu_pkg::*;

  // The predictor stores at most this many entries of a table; longer ones test overflow.
  localparam int TableCap = 64;

  logic        clk_i;
  logic        rst_ni;
  logic        start;
  logic        busy;
  logic [7:0]  sample_value_i;
  logic [15:0] frequency_i;
  logic        final_entry_i;
  logic        done_o;
  logic [15:0] mean_q8_o;
  logic [7:0]  mode_value_o;
  logic [7:0]  median_value_o;
  logic [15:0] stddev_q8_o;
  logic [7:0]  value_range_o;
  logic [23:0] variation_pct_q8_o;
  logic [1:0]  status_o;

  frequency_table_statistics_unit dut (.*);

  typedef struct packed {
    logic [15:0] mean;
    logic [7:0]  mode;
    logic [7:0]  median;
    logic [15:0] stddev;
    logic [7:0]  range_v;
    logic [23:0] cv;
    status_e     status;
  } stats_t;

  // Predictor state: one table under construction.
  logic [7:0]  tbl_val [TableCap];
  logic [15:0] tbl_cnt [TableCap];
  int unsigned tbl_n;
  logic [63:0] tot, wsum, sqsum;
  logic [15:0] top_cnt;
  logic [7:0]  top_val, first_v;
  status_e     err;

  stats_t      pending_stats[$];
  int          errors;
  int          tables_done;
  int          requests_sent;

  always begin
    clk_i = 1'b1; #2;
    clk_i = 1'b0; #2;
  end

  initial begin
    #50ms;
    $display("frequency_table_statistics_unit regression: fail");
    $finish;
  end

  function automatic logic [63:0] isqrt(logic [63:0] x);
    logic [63:0] root, bitv;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > x) bitv >>= 2;
    while (bitv != 0) begin
      if (x >= root + bitv) begin
        x -= root + bitv;
        root = (root >> 1) + bitv;
      end else begin
        root >>= 1;
      end
      bitv >>= 2;
    end
    return root;
  endfunction

  task automatic clear_table();
    tbl_n = 0; tot = 0; wsum = 0; sqsum = 0;
    top_cnt = 0; top_val = 0; first_v = 0; err = ST_OK;
  endtask

  // Fold one accepted request into the table; on the last one, push expected stats.
  task automatic fold_entry(logic [7:0] v, logic [15:0] f, logic last);
    stats_t s;
    logic [63:0] d, a, b, var_q16, mean, sd, cv, half, cum;
    if (tbl_n < MaxEntries) begin
      if (f == 0 && err == ST_OK) err = ST_ZERO_FREQ;
      if (tbl_n == 0) first_v = v;
      tbl_val[tbl_n] = v;
      tbl_cnt[tbl_n] = f;
      tbl_n++;
      tot += 64'(f);
      wsum += 64'(f) * v;
      sqsum += 64'(f) * v * v;
      if (f > top_cnt) begin
        top_cnt = f;
        top_val = v;
      end
    end else if (err == ST_OK) begin
      err = ST_OVERFLOW;
    end
    if (!last) return;
    mean = 0; sd = 0; cv = 0;
    if (tot != 0) begin
      d = tot * sqsum - wsum * wsum;
      a = d / tot;
      b = d % tot;
      var_q16 = (a * 65536 + (b * 65536) / tot) / tot;
      mean = (wsum * 256) / tot;
      if (mean > 16'hFFFF) mean = 16'hFFFF;
      sd = isqrt(var_q16);
      if (sd > 16'hFFFF) sd = 16'hFFFF;
      if (mean != 0) begin
        cv = (sd * CvScale) / mean;
        if (cv > 24'hFFFFFF) cv = 24'hFFFFFF;
      end
    end
    half = tot / 2;
    cum = 0;
    s.median = tbl_val[0];
    for (int i = 0; i < tbl_n; i++) begin
      cum += 64'(tbl_cnt[i]);
      if (cum >= half) begin
        s.median = tbl_val[i];
        break;
      end
    end
    s.mean = mean[15:0];
    s.stddev = sd[15:0];
    s.cv = cv[23:0];
    s.mode = top_val;
    s.range_v = tbl_val[tbl_n - 1] - first_v;
    s.status = err;
    pending_stats.push_back(s);
    clear_table();
  endtask

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    errors++;
    $display("%0t: mismatch on %s: got %0h, want %0h", $realtime, what, got, want);
  endtask

  // Check every strobed result against the oldest pending table.
  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (pending_stats.size() == 0) begin
        report("unexpected result", 1, 0);
      end else begin
        stats_t w;
        w = pending_stats.pop_front();
        tables_done++;
        if (mean_q8_o !== w.mean) report("mean_q8", mean_q8_o, w.mean);
        if (mode_value_o !== w.mode) report("mode_value", mode_value_o, w.mode);
        if (median_value_o !== w.median) report("median_value", median_value_o, w.median);
        if (stddev_q8_o !== w.stddev) report("stddev_q8", stddev_q8_o, w.stddev);
        if (value_range_o !== w.range_v) report("value_range", value_range_o, w.range_v);
        if (variation_pct_q8_o !== w.cv)
          report("variation_pct_q8", variation_pct_q8_o, w.cv);
        if (status_o !== w.status) report("status", status_o, w.status);
      end
    end
  end

  // Drive one request after a random gap; hold start until busy is low at an edge.
  task automatic send(logic [7:0] v, logic [15:0] f, logic last, bit no_gap = 0);
    int gap;
    gap = no_gap ? 0 : ($urandom_range(0, 3) == 0 ? $urandom_range(0, 15) : 0);
    repeat (gap) @(negedge clk_i);
    start = 1'b1;
    sample_value_i = v;
    frequency_i = f;
    final_entry_i = last;
    do @(posedge clk_i); while (busy);
    fold_entry(v, f, last);
    requests_sent++;
    @(negedge clk_i);
    start = 1'b0;
  endtask

  // Random table: mostly ascending values with random counts, some noise.
  task automatic send_random_table();
    int n, kind;
    logic [7:0] v;
    logic [15:0] f;
    kind = $urandom_range(0, 19);
    n = (kind == 0) ? $urandom_range(65, 70) : $urandom_range(1, 12);
    if (kind == 1) n = 64;
    v = 8'($urandom_range(0, 40));
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 5))
        0: f = 16'($urandom);
        1: f = 16'hFFFF;
        default: f = 16'($urandom_range(1, 300));
      endcase
      if (kind == 2 && $urandom_range(0, 3) == 0) f = 0;
      if (kind == 3) v = 8'($urandom);
      else v = v + 8'($urandom_range(0, 20));
      send(v, f, i == n - 1, kind == 4);
    end
  endtask

  typedef struct {
    logic [7:0]  v;
    logic [15:0] f;
    logic        last;
  } entry_row_t;

  // Directed tables: single entry, extremes, zero count, ties, descending values.
  entry_row_t directed_rows[] = '{
    '{8'd0,   16'd1,     1'b1},
    '{8'd255, 16'hFFFF,  1'b1},
    '{8'd7,   16'd0,     1'b1},
    '{8'd0,   16'hFFFF,  1'b0}, '{8'd255, 16'hFFFF, 1'b1},
    '{8'd10,  16'd5,     1'b0}, '{8'd20,  16'd5,     1'b0}, '{8'd30, 16'd2, 1'b1},
    '{8'd1,   16'd3,     1'b0}, '{8'd2,   16'd0,     1'b0}, '{8'd3,  16'd9, 1'b1},
    '{8'd200, 16'd4,     1'b0}, '{8'd5,   16'd4,     1'b1},
    '{8'd0,   16'd0,     1'b0}, '{8'd0,   16'd0,     1'b1},
    '{8'd170, 16'h5555,  1'b0}, '{8'd85,  16'hAAAA,  1'b1}
  };

  initial begin
    errors = 0; tables_done = 0; requests_sent = 0;
    start = 1'b0; sample_value_i = '0; frequency_i = '0; final_entry_i = 1'b0;
    clear_table();
    rst_ni = 1'b0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (directed_rows[i]) send(directed_rows[i].v, directed_rows[i].f, directed_rows[i].last);
    // Overflow: 66 entries, the last two are dropped but the final one still ends the table.
    for (int i = 0; i < 66; i++) send(i[7:0], 16'(i + 1), i == 65, 1);

    while (requests_sent < 1400) begin
      send_random_table();
      // Hold off now and then until every pending table has reported.
      if ($urandom_range(0, 9) == 0) begin
        while (pending_stats.size() != 0) @(negedge clk_i);
      end
    end

    while (pending_stats.size() != 0) @(negedge clk_i);
    repeat (300) @(negedge clk_i);
    $display("Covered %0d requests in %0d tables, incl. zero counts, overflow, extremes.",
             requests_sent, tables_done);
    if (errors == 0 && pending_stats.size() == 0) begin
      $display("frequency_table_statistics_unit regression: pass");
    end else begin
      $display("frequency_table_statistics_unit regression: fail");
    end
    $finish;
  end

endmodule
